/* hdl/voxel_ray_pick_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the voxel ray picker checker
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef VOXEL_RAY_PICK_CORE_MACROS_SVH
`define VOXEL_RAY_PICK_CORE_MACROS_SVH

// same-cycle implication
`define VRP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("voxel_ray_pick_core check failed");

// next-cycle implication
`define VRP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("voxel_ray_pick_core check failed");

`endif

/* hdl/vrp_pkg.sv */
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types and constants of the voxel ray picker.
// ----------------------------------------------------------------------------
package vrp_pkg;

	localparam int GRID_BITS_DEF = 6;
	localparam int DIST_W        = 40;          // Q.24 voxel distance
	localparam int QUO_W         = 39;          // bits of 2^38 / mag
	localparam int MAG_W         = 16;
	localparam int POS_W         = 11;          // signed walk index
	localparam int MAXD_W        = 14;

	typedef logic [DIST_W-1:0] dist_t;

	localparam dist_t DIST_MAX = {DIST_W{1'b1}};
	localparam logic [MAXD_W-1:0] MAXD_RESET = 14'd768;

	localparam logic [2:0] FACE_DOWN  = 3'd0;
	localparam logic [2:0] FACE_UP    = 3'd1;
	localparam logic [2:0] FACE_BACK  = 3'd2;
	localparam logic [2:0] FACE_FRONT = 3'd3;
	localparam logic [2:0] FACE_LEFT  = 3'd4;
	localparam logic [2:0] FACE_RIGHT = 3'd5;

endpackage

/* hdl/vrp_map.sv */
// ----------------------------------------------------------------------------
// vrp_map
// One-bit occupancy memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module vrp_map #(
	parameter int ADDR_W = 18
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic              wr_bit,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic              rd_bit,
	output logic              clearing
);
	logic              mem [2**ADDR_W];
	logic [ADDR_W:0]   clr_cnt_q;

	assign clearing = !clr_cnt_q[ADDR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clearing) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing) begin
			mem[clr_cnt_q[ADDR_W-1:0]] <= 1'b0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_bit;
		end
		rd_bit <= mem[rd_addr];
	end

endmodule

/* hdl/vrp_div.sv */
// ----------------------------------------------------------------------------
// vrp_div
// Radix-2 restoring divider for step distance 2^38 / mag, one bit a cycle.
// ----------------------------------------------------------------------------
module vrp_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [vrp_pkg::MAG_W-1:0] mag,
	output logic                     done,
	output vrp_pkg::dist_t           quo
);
	import vrp_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic             zero_q;
	logic [5:0]       cnt_q;
	logic [MAG_W-1:0] mag_q;
	logic [MAG_W-2:0] rem_q;
	logic [QUO_W-1:0] q_q;
	logic [MAG_W-1:0] rem_sh;
	logic             ge;

	// dividend is a single one at the top bit
	assign rem_sh = {rem_q, (cnt_q == 6'(QUO_W - 1))};
	assign ge     = rem_sh >= mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= (mag != '0);
				done_q <= (mag == '0);
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q  <= mag;
			zero_q <= (mag == '0);
			cnt_q  <= 6'(QUO_W - 1);
			rem_q  <= '0;
			q_q    <= '0;
		end else if (busy_q) begin
			q_q   <= {q_q[QUO_W-2:0], ge};
			rem_q <= ge ? (MAG_W-1)'(rem_sh - mag_q) : rem_sh[MAG_W-2:0];
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done = done_q;
	assign quo  = zero_q ? DIST_MAX : {1'b0, q_q};

endmodule

/* hdl/voxel_ray_pick_core.sv */
// ----------------------------------------------------------------------------
// voxel_ray_pick_core
// Voxel solid map with a 3D DDA ray picker.
// ----------------------------------------------------------------------------
// A write item (op 0) sets one voxel bit. A cast item (op 1) runs a setup
// per axis, paced by the shared one-bit-a-cycle divider that forms each axis
// step distance, then a step and a test state per DDA step (step, then
// occupancy memory read and test), then a final state that posts the
// result once the output slot is free. in_stall stays high for the whole
// cast. After reset the map is swept clear, one voxel a cycle, over all
// 2^(GRID_X_BITS+GRID_Y_BITS+GRID_Z_BITS) voxels (262144 at the default
// size); items are held off in that time, configuration writes are taken.
// ----------------------------------------------------------------------------
module voxel_ray_pick_core #(
	parameter int GRID_X_BITS = vrp_pkg::GRID_BITS_DEF,
	parameter int GRID_Y_BITS = vrp_pkg::GRID_BITS_DEF,
	parameter int GRID_Z_BITS = vrp_pkg::GRID_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_we,
	input  logic [vrp_pkg::MAXD_W-1:0] cfg_wdata,
	// input items
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic [5:0]                 vox_x,
	input  logic [5:0]                 vox_y,
	input  logic [5:0]                 vox_z,
	input  logic                       solid,
	input  logic signed [15:0]         start_x,
	input  logic signed [15:0]         start_y,
	input  logic signed [15:0]         start_z,
	input  logic signed [15:0]         dir_x,
	input  logic signed [15:0]         dir_y,
	input  logic signed [15:0]         dir_z,
	// result items
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       hit,
	output logic [5:0]                 hit_x,
	output logic [5:0]                 hit_y,
	output logic [5:0]                 hit_z,
	output logic [2:0]                 face
);
	import vrp_pkg::*;

	localparam int ADDR_W = GRID_X_BITS + GRID_Y_BITS + GRID_Z_BITS;
	localparam int LIM_X  = 1 << GRID_X_BITS;
	localparam int LIM_Y  = 1 << GRID_Y_BITS;
	localparam int LIM_Z  = 1 << GRID_Z_BITS;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_LOAD = 7'b0000010,
		S_DIV  = 7'b0000100,
		S_MUL  = 7'b0001000,
		S_STEP = 7'b0010000,
		S_TEST = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t                   state_q;
	logic [MAXD_W-1:0]        maxd_q;
	logic [1:0]               ax_q;
	logic signed [15:0]       s_q   [3];
	logic signed [15:0]       d_q   [3];
	dist_t                    delta_q [3];
	dist_t                    side_q  [3];
	logic signed [POS_W-1:0]  pos_q [3];
	logic                     neg_q [3];
	dist_t                    trav_q;
	logic                     in_grid_q;
	logic [2:0]               face_q;

	logic                     res_hit_q;
	logic [5:0]               res_x_q, res_y_q, res_z_q;
	logic [2:0]               res_face_q;
	logic                     out_valid_q;

	logic                     clearing;
	logic                     in_acc;
	logic                     slot_free;
	logic                     div_start;
	logic                     div_done;
	dist_t                    div_quo;
	logic [MAG_W-1:0]         mag;
	logic [8:0]               f_dist;
	logic [DIST_W+8:0]        prod;
	logic [1:0]               sel;
	logic signed [POS_W-1:0]  npos [3];
	logic                     n_in_grid;
	logic [DIST_W:0]          side_sum;
	dist_t                    side_next;
	dist_t                    limit;
	logic                     map_bit;
	logic [ADDR_W-1:0]        wr_addr;
	logic [ADDR_W-1:0]        rd_addr;
	logic [2:0]               step_face;

	assign in_stall  = clearing || (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign limit     = DIST_W'({maxd_q, 16'h0000});

	// axis setup: magnitude for the divider, distance to the first boundary
	assign mag       = d_q[ax_q][15] ? MAG_W'(-d_q[ax_q]) : MAG_W'(d_q[ax_q]);
	assign div_start = (state_q == S_LOAD);
	assign f_dist    = neg_q[ax_q] ? {1'b0, s_q[ax_q][7:0]}
	                               : 9'd256 - {1'b0, s_q[ax_q][7:0]};
	assign prod      = f_dist * delta_q[ax_q];

	// smallest side distance; ties go to y over x and z over y
	always_comb begin
		if (side_q[0] < side_q[1] && side_q[0] < side_q[2]) begin
			sel       = 2'd0;
			step_face = neg_q[0] ? FACE_RIGHT : FACE_LEFT;
		end else if (side_q[1] < side_q[2]) begin
			sel       = 2'd1;
			step_face = neg_q[1] ? FACE_UP : FACE_DOWN;
		end else begin
			sel       = 2'd2;
			step_face = neg_q[2] ? FACE_FRONT : FACE_BACK;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (sel == 2'(i)) begin
				npos[i] = neg_q[i] ? pos_q[i] - 1'b1 : pos_q[i] + 1'b1;
			end else begin
				npos[i] = pos_q[i];
			end
		end
	end

	assign side_sum  = {1'b0, side_q[sel]} + {1'b0, delta_q[sel]};
	assign side_next = side_sum[DIST_W] ? DIST_MAX : side_sum[DIST_W-1:0];

	assign n_in_grid = (npos[0] >= 0) && (int'(npos[0]) < LIM_X) &&
	                   (npos[1] >= 0) && (int'(npos[1]) < LIM_Y) &&
	                   (npos[2] >= 0) && (int'(npos[2]) < LIM_Z);

	assign rd_addr = {GRID_Z_BITS'(unsigned'(npos[2])),
	                  GRID_Y_BITS'(unsigned'(npos[1])),
	                  GRID_X_BITS'(unsigned'(npos[0]))};
	assign wr_addr = {GRID_Z_BITS'(vox_z), GRID_Y_BITS'(vox_y), GRID_X_BITS'(vox_x)};

	vrp_map #(
		.ADDR_W (ADDR_W)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_acc && !op),
		.wr_addr  (wr_addr),
		.wr_bit   (solid),
		.rd_addr  (rd_addr),
		.rd_bit   (map_bit),
		.clearing (clearing)
	);

	vrp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (mag),
		.done   (div_done),
		.quo    (div_quo)
	);

	// max_distance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxd_q <= MAXD_RESET;
		end else if (cfg_we) begin
			maxd_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ax_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && op) begin
						ax_q    <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (ax_q == 2'd2) begin
						state_q <= S_TEST;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_STEP: begin
					state_q <= S_TEST;
				end
				S_TEST: begin
					if ((in_grid_q && map_bit) || !(trav_q < limit)) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc && op) begin
			s_q[0] <= start_x;
			s_q[1] <= start_y;
			s_q[2] <= start_z;
			d_q[0] <= dir_x;
			d_q[1] <= dir_y;
			d_q[2] <= dir_z;
		end
		if (state_q == S_LOAD) begin
			neg_q[ax_q] <= d_q[ax_q][15];
			// voxel index is the signed integer part of the origin
			pos_q[ax_q] <= POS_W'(signed'(s_q[ax_q][15:8]));
		end
		if (state_q == S_DIV && div_done) begin
			delta_q[ax_q] <= div_quo;
		end
		if (state_q == S_MUL) begin
			side_q[ax_q] <= prod[DIST_W+7:8];
			// starting voxel is not tested
			trav_q       <= '0;
			in_grid_q    <= 1'b0;
		end
		if (state_q == S_STEP) begin
			trav_q       <= side_q[sel];
			side_q[sel]  <= side_next;
			pos_q[0]     <= npos[0];
			pos_q[1]     <= npos[1];
			pos_q[2]     <= npos[2];
			in_grid_q    <= n_in_grid;
			face_q       <= step_face;
		end
		if (state_q == S_TEST) begin
			if (in_grid_q && map_bit) begin
				res_hit_q  <= 1'b1;
				res_x_q    <= pos_q[0][5:0];
				res_y_q    <= pos_q[1][5:0];
				res_z_q    <= pos_q[2][5:0];
				res_face_q <= face_q;
			end else begin
				res_hit_q  <= 1'b0;
				res_x_q    <= '0;
				res_y_q    <= '0;
				res_z_q    <= '0;
				res_face_q <= FACE_DOWN;
			end
		end
		if (state_q == S_FIN && slot_free) begin
			hit   <= res_hit_q;
			hit_x <= res_x_q;
			hit_y <= res_y_q;
			hit_z <= res_z_q;
			face  <= res_face_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* hdl/vrp_chk.sv */
// ----------------------------------------------------------------------------
// vrp_chk
// Port-level checks of the voxel ray picker, bound to the top level.
// ----------------------------------------------------------------------------
`include "voxel_ray_pick_core_macros.svh"

module vrp_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       op,
	input logic       out_valid,
	input logic       out_stall,
	input logic       hit,
	input logic [5:0] hit_x,
	input logic [5:0] hit_y,
	input logic [5:0] hit_z,
	input logic [2:0] face
);
	`VRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`VRP_ASSERT_NEXT(a_cast_busy, in_valid && !in_stall && op, in_stall)
	`VRP_ASSERT_NOW(a_miss_zero, out_valid && !hit, hit_x == 0 && hit_y == 0 && hit_z == 0 && face == 0)
	`VRP_ASSERT_NOW(a_face_code, out_valid, face != 3'd6 && face != 3'd7)

endmodule

bind voxel_ray_pick_core vrp_chk u_vrp_chk (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks voxel_ray_pick_core: voxel writes build a solid map in a local model,
// each cast is walked voxel by voxel in the model and the picked voxel and
// face are compared with the result items, under several idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;
	import vrp_pkg::*;

	// one input item, one field per port
	typedef struct {
		logic              op;
		logic [5:0]        vx, vy, vz;
		logic              solid;
		logic signed [15:0] sx, sy, sz;
		logic signed [15:0] dx, dy, dz;
	} vox_cmd_t;

	// one pick result
	typedef struct {
		logic       hit;
		logic [5:0] hx, hy, hz;
		logic [2:0] face;
	} pick_t;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [MAXD_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = 1'b0;
	logic [5:0] vox_x = '0, vox_y = '0, vox_z = '0;
	logic solid = 1'b0;
	logic signed [15:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic [5:0] hit_x, hit_y, hit_z;
	logic [2:0] face;

	voxel_ray_pick_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .op(op),
		.vox_x(vox_x), .vox_y(vox_y), .vox_z(vox_z), .solid(solid),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z), .face(face)
	);

	// model state: solid map, reach register
	bit          solid_map [0:262143];
	logic [MAXD_W-1:0] reach_q = MAXD_RESET;

	pick_t pending_picks [$];
	int    fail_cnt = 0;
	int    cast_cnt = 0;
	int    hit_cnt = 0;
	int    write_cnt = 0;

	// idle knobs: percent per cycle, and a counted receiver hold request
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int recv_hold_req = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------
	// model
	// ------------------------------------------------------------------
	function automatic bit voxel_solid(longint x, longint y, longint z);
		if (x < 0 || y < 0 || z < 0 || x > 63 || y > 63 || z > 63)
			return 1'b0;
		return solid_map[z * 4096 + y * 64 + x];
	endfunction

	// DDA walk; ties go to y over x and z over y
	function automatic pick_t trace_ray(vox_cmd_t c);
		longint p [3];
		longint dl [3];
		longint sd [3];
		longint s, d, fr, mag, f, travel, lim, dmax;
		int st [3];
		int ax;
		bit done;
		logic [2:0] fc;
		pick_t r;
		logic signed [15:0] sv [3];
		logic signed [15:0] dv [3];
		sv[0] = c.sx; sv[1] = c.sy; sv[2] = c.sz;
		dv[0] = c.dx; dv[1] = c.dy; dv[2] = c.dz;
		dmax = longint'(DIST_MAX);
		r.hit = 1'b0; r.hx = '0; r.hy = '0; r.hz = '0; r.face = '0;
		for (int a = 0; a < 3; a++) begin
			s = sv[a];
			d = dv[a];
			fr = ((s % 256) + 256) % 256;
			p[a] = (s - fr) / 256;
			mag = (d < 0) ? -d : d;
			dl[a] = (mag != 0) ? ((longint'(1) << 38) / mag) : dmax;
			if (dl[a] > dmax)
				dl[a] = dmax;
			if (d < 0) begin
				st[a] = -1;
				f = fr;
			end else begin
				st[a] = 1;
				f = 256 - fr;
			end
			sd[a] = (f * dl[a]) >> 8;
		end
		lim = longint'(reach_q) << 16;
		travel = 0;
		done = 1'b0;
		while (!done && travel < lim) begin
			if (sd[0] < sd[1] && sd[0] < sd[2]) begin
				ax = 0;
				fc = (st[0] < 0) ? FACE_RIGHT : FACE_LEFT;
			end else if (sd[1] < sd[2]) begin
				ax = 1;
				fc = (st[1] < 0) ? FACE_UP : FACE_DOWN;
			end else begin
				ax = 2;
				fc = (st[2] < 0) ? FACE_FRONT : FACE_BACK;
			end
			travel = sd[ax];
			sd[ax] = sd[ax] + dl[ax];
			if (sd[ax] > dmax)
				sd[ax] = dmax;
			p[ax] = p[ax] + st[ax];
			if (voxel_solid(p[0], p[1], p[2])) begin
				r.hit = 1'b1;
				r.hx = p[0][5:0];
				r.hy = p[1][5:0];
				r.hz = p[2][5:0];
				r.face = fc;
				done = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic void apply_cmd(vox_cmd_t c);
		pick_t r;
		if (c.op == OP_WRITE) begin
			solid_map[{c.vz, c.vy, c.vx}] = c.solid;
			write_cnt++;
		end else begin
			r = trace_ray(c);
			pending_picks.push_back(r);
			cast_cnt++;
			if (r.hit)
				hit_cnt++;
		end
	endfunction

	// ------------------------------------------------------------------
	// item builders
	// ------------------------------------------------------------------
	function automatic vox_cmd_t mk_write(int x, int y, int z, bit sb);
		vox_cmd_t c;
		c = '{default: '0};
		c.op = OP_WRITE;
		c.vx = x[5:0]; c.vy = y[5:0]; c.vz = z[5:0];
		c.solid = sb;
		// cast fields are don't-care here, keep them moving
		c.sx = $urandom; c.sy = $urandom; c.sz = $urandom;
		c.dx = $urandom; c.dy = $urandom; c.dz = $urandom;
		return c;
	endfunction

	function automatic vox_cmd_t mk_cast(int sx, int sy, int sz, int dx, int dy, int dz);
		vox_cmd_t c;
		c.op = OP_CAST;
		c.vx = $urandom; c.vy = $urandom; c.vz = $urandom;
		c.solid = $urandom;
		c.sx = sx[15:0]; c.sy = sy[15:0]; c.sz = sz[15:0];
		c.dx = dx[15:0]; c.dy = dy[15:0]; c.dz = dz[15:0];
		return c;
	endfunction

	function automatic int rand_dir();
		int k;
		k = $urandom_range(19);
		if (k == 0)
			return 0;
		if (k == 1)
			return $urandom;           // any 16-bit pattern, non-unit
		if (k == 2)
			return $urandom_range(1) ? 16384 : -16384;
		return int'($urandom_range(32768)) - 16384;
	endfunction

	// scene: a few voxels around a center, then rays, mostly from nearby
	task automatic run_scene();
		int cx, cy, cz;
		cx = $urandom_range(63); cy = $urandom_range(63); cz = $urandom_range(63);
		repeat ($urandom_range(8, 3))
			send_cmd(mk_write(cx + int'($urandom_range(6)) - 3,
				cy + int'($urandom_range(6)) - 3,
				cz + int'($urandom_range(6)) - 3, $urandom_range(5) != 0));
		repeat ($urandom_range(4, 1)) begin
			if ($urandom_range(9) == 0)
				send_cmd(mk_cast($urandom, $urandom, $urandom,
					rand_dir(), rand_dir(), rand_dir()));
			else
				send_cmd(mk_cast(cx * 256 + int'($urandom_range(1024)) - 512,
					cy * 256 + int'($urandom_range(1024)) - 512,
					cz * 256 + int'($urandom_range(1024)) - 512,
					rand_dir(), rand_dir(), rand_dir()));
		end
	endtask

	// ------------------------------------------------------------------
	// driving
	// ------------------------------------------------------------------
	// valid is left high after acceptance; release_bus lowers it
	task automatic send_cmd(vox_cmd_t c);
		while (int'($urandom_range(99)) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		op <= c.op;
		vox_x <= c.vx; vox_y <= c.vy; vox_z <= c.vz;
		solid <= c.solid;
		start_x <= c.sx; start_y <= c.sy; start_z <= c.sz;
		dir_x <= c.dx; dir_y <= c.dy; dir_z <= c.dz;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_cmd(c);
	endtask

	task automatic release_bus();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every pick, then let a trailing write settle
	task automatic drain();
		release_bus();
		while (pending_picks.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reach(logic [MAXD_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		reach_q = v;
	endtask

	// receiver: random stall, or a long counted hold on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (recv_hold_req != 0) begin
				hold_left = recv_hold_req;
				recv_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= (int'($urandom_range(99)) < recv_stall_pct);
			end
		end
	end

	// result checker
	initial begin
		pick_t e;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_picks.size() == 0) begin
					$error("unexpected result item: hit=%0d x=%0d y=%0d z=%0d face=%0d",
						hit, hit_x, hit_y, hit_z, face);
					fail_cnt++;
				end else begin
					e = pending_picks.pop_front();
					if (hit !== e.hit) begin
						$error("hit: expected %0d, got %0d", e.hit, hit);
						fail_cnt++;
					end
					if (hit_x !== e.hx) begin
						$error("hit_x: expected %0d, got %0d", e.hx, hit_x);
						fail_cnt++;
					end
					if (hit_y !== e.hy) begin
						$error("hit_y: expected %0d, got %0d", e.hy, hit_y);
						fail_cnt++;
					end
					if (hit_z !== e.hz) begin
						$error("hit_z: expected %0d, got %0d", e.hz, hit_z);
						fail_cnt++;
					end
					if (face !== e.face) begin
						$error("face: expected %0d, got %0d", e.face, face);
						fail_cnt++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// corners, each face, zero and oversized directions, reset reach
	task automatic test_directed();
		send_cmd(mk_cast(32 * 256 + 128, 32 * 256 + 128, 32 * 256 + 128, 16384, 0, 0));
		send_cmd(mk_write(0, 0, 0, 1'b1));
		send_cmd(mk_write(63, 63, 63, 1'b1));
		send_cmd(mk_cast(-128, 128, 128, 16384, 0, 0));        // enters from outside
		send_cmd(mk_cast(63 * 256 + 128, 63 * 256 + 128, 65 * 256, 0, 0, -16384));
		send_cmd(mk_write(33, 32, 32, 1'b1));
		send_cmd(mk_write(31, 32, 32, 1'b1));
		send_cmd(mk_write(32, 33, 32, 1'b1));
		send_cmd(mk_write(32, 31, 32, 1'b1));
		send_cmd(mk_write(32, 32, 33, 1'b1));
		send_cmd(mk_write(32, 32, 31, 1'b1));
		send_cmd(mk_cast(8320, 8320, 8320, 16384, 0, 0));
		send_cmd(mk_cast(8320, 8320, 8320, -16384, 0, 0));
		send_cmd(mk_cast(8320, 8320, 8320, 0, 16384, 0));
		send_cmd(mk_cast(8320, 8320, 8320, 0, -16384, 0));
		send_cmd(mk_cast(8320, 8320, 8320, 0, 0, 16384));
		send_cmd(mk_cast(8320, 8320, 8320, 0, 0, -16384));
		send_cmd(mk_cast(8320, 8320, 8320, 0, 0, 0));           // all zero: z wins ties
		send_cmd(mk_cast(8192, 8192, 8192, 11585, 11585, 0));   // exact tie x/y
		send_cmd(mk_cast(8320, 8320, 8320, -32768, 32767, -32768));
		send_cmd(mk_write(32, 33, 32, 1'b0));                   // clear a voxel
		send_cmd(mk_cast(8320, 8320, 8320, 0, 16384, 0));
		send_cmd(mk_cast(-32768, 32767, -32768, 16384, -16384, 16384));
		send_cmd(mk_cast(32767, -32768, 0, 1, -1, 0));          // tiny components
		drain();
	endtask

	task automatic test_idle_phase(int s_pct, int r_pct, int n_items);
		int start_cnt;
		sender_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		start_cnt = write_cnt + cast_cnt;
		while (write_cnt + cast_cnt - start_cnt < n_items)
			run_scene();
		drain();
	endtask

	// reach register at its extremes; big reaches get few rays
	task automatic test_reach(logic [MAXD_W-1:0] v, int n_items);
		write_reach(v);
		test_idle_phase(20, 20, n_items);
	endtask

	// receiver holds off while casts keep coming, then the sender waits
	task automatic test_backpressure();
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold_req = 3000;
		repeat (12)
			send_cmd(mk_cast(int'($urandom_range(16383)), int'($urandom_range(16383)),
				int'($urandom_range(16383)), rand_dir(), rand_dir(), rand_dir()));
		drain();
		repeat (4) run_scene();
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_idle_phase(0, 0, 180);
		test_idle_phase(75, 0, 180);
		test_idle_phase(0, 75, 180);
		test_idle_phase(35, 35, 180);
		test_backpressure();
		test_reach(14'd0, 20);
		test_reach(14'd256, 30);
		test_reach(14'd8192, 25);
		test_reach(14'd16383, 10);
		test_reach(14'd1000, 20);
		release_bus();
		while (pending_picks.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("Covered %0d voxel writes and %0d casts (%0d hits) over five idle mixes",
			write_cnt, cast_cnt, hit_cnt);
		$display("and reach settings 0 to 16383, with a long result hold-off.");
		if (fail_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
